/* hdl/serial_command_rom_loader_defines.svh */
`ifndef SERIAL_COMMAND_ROM_LOADER_DEFINES_SVH
`define SERIAL_COMMAND_ROM_LOADER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SCRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scrl check failed");

// Check that cons holds in the cycle after ante.
`define SCRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scrl check failed");

`endif

/* hdl/scrl_pkg.sv */
`timescale 1ns / 1ps

package scrl_pkg;

  // Payload memory address width, 12 to 16.
  localparam int unsigned AddrWidth = 16;
  localparam logic [15:0] OffsetMask = 16'((32'd1 << AddrWidth) - 32'd1);

  localparam logic [31:0] CtrlReset = 32'hFFFF_FFFF;
  localparam logic [31:0] BankClrMask = 32'hFFFF_00FF;
  localparam int unsigned LoadBit = 6;

  // Command bytes
  localparam logic [7:0] CmdSleep   = 8'hA0;
  localparam logic [7:0] CmdClrB0   = 8'hA1;
  localparam logic [7:0] CmdSetB0   = 8'hA2;
  localparam logic [7:0] CmdClrB1   = 8'hA3;
  localparam logic [7:0] CmdSetB1   = 8'hA4;
  localparam logic [7:0] CmdUpload  = 8'hA5;
  localparam logic [7:0] CmdSetB3   = 8'hA6;
  localparam logic [7:0] CmdClrB3   = 8'hA7;
  localparam logic [7:0] CmdSetB2   = 8'hA8;
  localparam logic [7:0] CmdClrB2   = 8'hA9;
  localparam logic [7:0] CmdSetB4   = 8'hAA;
  localparam logic [7:0] CmdClrB4   = 8'hAB;

  typedef enum logic [1:0] {
    MODE_SLEEP = 2'd0,
    MODE_CMD   = 2'd1,
    MODE_LEN   = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic        have_low;
    logic [15:0] len;
    logic [31:0] ctrl;
    logic [15:0] wcnt;
  } scrl_state_t;

  typedef struct packed {
    logic        unknown_cmd;
    logic [1:0]  cur_mode;
    logic [7:0]  mem_data;
    logic [15:0] mem_offset;
    logic        mem_write;
    logic [31:0] control_word;
  } scrl_result_t;

  function automatic logic [7:0] bank_code(input logic [15:0] len);
    logic [7:0] code;
    case (len)
      16'd4096:  code = 8'h01;
      16'd8192:  code = 8'hF8;
      16'd16384: code = 8'hF6;
      16'd32768: code = 8'hF4;
      default:   code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* hdl/scrl_step.sv */
`timescale 1ns / 1ps

module scrl_step import scrl_pkg::*; (
  input  scrl_state_t  state_i,
  input  logic [7:0]   rx_byte_i,
  output scrl_state_t  state_o,
  output scrl_result_t result_o
);

  logic [15:0] len_full;
  logic [15:0] wcnt_inc;
  logic        unk;
  logic        wr;

  assign len_full = {rx_byte_i, state_i.len[7:0]};
  assign wcnt_inc = state_i.wcnt + 16'd1;

  always_comb begin
    state_o = state_i;
    unk     = 1'b0;
    wr      = 1'b0;
    unique case (state_i.mode)
      MODE_SLEEP: begin
        if (rx_byte_i == CmdSleep) state_o.mode = MODE_CMD;
      end
      MODE_LEN: begin
        if (!state_i.have_low) begin
          state_o.len      = {8'd0, rx_byte_i};
          state_o.have_low = 1'b1;
        end else begin
          state_o.len            = len_full;
          state_o.have_low       = 1'b0;
          state_o.ctrl           = (state_i.ctrl & BankClrMask)
                                   | {16'd0, bank_code(len_full), 8'd0};
          state_o.wcnt           = 16'd0;
          // zero length: bit 6 ends clear, straight back to command mode
          state_o.ctrl[LoadBit]  = (len_full != 16'd0);
          state_o.mode           = (len_full != 16'd0) ? MODE_LOAD : MODE_CMD;
        end
      end
      MODE_LOAD: begin
        wr           = 1'b1;
        state_o.wcnt = wcnt_inc;
        if (wcnt_inc == state_i.len) begin
          state_o.ctrl[LoadBit] = 1'b0;
          state_o.mode          = MODE_CMD;
        end
      end
      MODE_CMD: begin
        unique case (rx_byte_i)
          CmdSleep:  state_o.mode = MODE_SLEEP;
          CmdClrB0:  state_o.ctrl[0] = 1'b0;
          CmdSetB0:  state_o.ctrl[0] = 1'b1;
          CmdClrB1:  state_o.ctrl[1] = 1'b0;
          CmdSetB1:  state_o.ctrl[1] = 1'b1;
          CmdUpload: begin
            state_o.mode     = MODE_LEN;
            state_o.have_low = 1'b0;
          end
          CmdSetB3:  state_o.ctrl[3] = 1'b1;
          CmdClrB3:  state_o.ctrl[3] = 1'b0;
          CmdSetB2:  state_o.ctrl[2] = 1'b1;
          CmdClrB2:  state_o.ctrl[2] = 1'b0;
          CmdSetB4:  state_o.ctrl[4] = 1'b1;
          CmdClrB4:  state_o.ctrl[4] = 1'b0;
          default:   unk = 1'b1;
        endcase
      end
      default: state_o = state_i;
    endcase
  end

  always_comb begin
    result_o.control_word = state_o.ctrl;
    result_o.mem_write    = wr;
    result_o.mem_offset   = wr ? (state_i.wcnt & OffsetMask) : 16'd0;
    result_o.mem_data     = wr ? rx_byte_i : 8'd0;
    result_o.cur_mode     = state_o.mode;
    result_o.unknown_cmd  = unk;
  end

endmodule

/* hdl/serial_command_rom_loader.sv */
`timescale 1ns / 1ps
// Channel   Dir  Fields (tdata, from bit 0 up)
// s_axis    in   rx_byte[7:0]
// m_axis    out  control_word[31:0], mem_write[32], mem_offset[48:33],
//                mem_data[56:49], cur_mode[58:57], unknown_cmd[59], zero[63:60]
//
// One byte per cycle sustained while the output is not stalled; a result passes
// through the input register, then the step logic into the result register.
// Reset puts the machine in sleep mode with the control word all ones.
// The command state advances only when the input register moves into a free
// result register, so a stalled output holds both stages in place.

`include "serial_command_rom_loader_defines.svh"

module serial_command_rom_loader import scrl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // control_word, mem_write, mem_offset,
                                        // mem_data, cur_mode, unknown_cmd
);

  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  logic         out_vld_q;
  scrl_result_t out_q;
  scrl_state_t  state_q;
  scrl_state_t  state_d;
  scrl_result_t result_d;
  logic         out_free;
  logic         advance;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || advance;

  scrl_step u_step (
    .state_i   (state_q),
    .rx_byte_i (in_byte_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      state_q.mode     <= MODE_SLEEP;
      state_q.have_low <= 1'b0;
      state_q.len      <= 16'd0;
      state_q.ctrl     <= CtrlReset;
      state_q.wcnt     <= 16'd0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (out_free) out_vld_q <= in_vld_q;
      if (advance) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_byte_q <= s_axis_tdata_i;
    if (advance) out_q <= result_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_q};

  // loading mode always has the load bit up
  `SCRL_ASSERT_NOW(a_load_bit, clk_i, rst_ni, state_q.mode == MODE_LOAD, state_q.ctrl[LoadBit])
  // low length half is only pending in length mode
  `SCRL_ASSERT_NOW(a_low_half, clk_i, rst_ni, state_q.mode != MODE_LEN, !state_q.have_low)
  // hold the command state while the result register is blocked
  `SCRL_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_vld_q && !m_axis_tready_i, $stable(state_q))

endmodule
